### hdl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define MST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define MST_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/mst_pkg.sv
package mst_pkg;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

  // Operation codes carried by the mode field.
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Minimum reported for an empty stack, and the value of a failed pop.
  localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [31:0] POP_EMPTY     = -32'sd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic emit;
  } mst_cmd_t;

endpackage

### hdl/mst_ctrl.sv
module mst_ctrl
  import mst_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output mst_cmd_t cmd
);

  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_MREAD  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // Commands are decoded from the state and the handshakes.
  always_comb begin
    in_ready    = (state == S_IDLE);
    cmd.capture = in_ready && in_valid;
    cmd.execute = (state == S_EXEC);
    cmd.emit    = (state == S_RESULT) && (!out_valid || out_ready);
  end

  // Next state: one pass through the reads and the update per request.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_READ;
      S_READ:   state_next = S_EXEC;
      S_EXEC:   state_next = S_MREAD;
      S_MREAD:  state_next = S_RESULT;
      S_RESULT: if (cmd.emit) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // The output register is full from a load until the consumer takes it.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  `MST_ASSERT(a_accept_to_exec, cmd.capture |-> ##2 (state == S_EXEC), "update not two cycles after accept")
  `MST_ASSERT(a_emit_sets_valid, cmd.emit |=> out_valid, "loaded result not presented")
  `MST_ASSERT(a_state_onehot, $onehot(state), "state register not one-hot")

endmodule

### hdl/mst_dp.sv
module mst_dp
  import mst_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  mst_cmd_t           cmd,
  input  logic               mode,
  input  logic signed [31:0] push_value,
  output logic signed [31:0] popped_value,
  output logic [1:0]         status,
  output logic signed [31:0] minimum,
  output logic               is_empty
);

  `include "assert_macros.svh"

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(STACK_DEPTH);
  localparam logic [CW-1:0] ONE_CNT   = CW'(1);

  logic signed [31:0] elem_mem [STACK_DEPTH];
  logic signed [31:0] min_mem  [STACK_DEPTH];

  logic               op_mode;
  logic signed [31:0] op_value;
  logic [CW-1:0]      ecount;
  logic [CW-1:0]      mcount;
  logic [CW-1:0]      ecount_next;
  logic [CW-1:0]      mcount_next;
  logic [CW-1:0]      ecount_m1;
  logic [CW-1:0]      mcount_m1;
  logic signed [31:0] elem_rdata;
  logic signed [31:0] min_rdata;
  logic signed [31:0] res_popped;
  logic [1:0]         res_status;
  logic signed [31:0] res_popped_next;
  logic [1:0]         res_status_next;
  logic               elem_we;
  logic               min_we;

  assign ecount_m1 = ecount - ONE_CNT;
  assign mcount_m1 = mcount - ONE_CNT;

  // Latch the request on acceptance.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_mode  <= mode;
      op_value <= push_value;
    end
  end

  // Stack memories: the tops are read every cycle, writes land above the tops.
  always_ff @(posedge clk) begin
    elem_rdata <= elem_mem[ecount_m1[AW-1:0]];
    min_rdata  <= min_mem[mcount_m1[AW-1:0]];
    if (elem_we) begin
      elem_mem[ecount[AW-1:0]] <= op_value;
    end
    if (min_we) begin
      min_mem[mcount[AW-1:0]] <= op_value;
    end
  end

  // Push or pop against the registered tops.
  always_comb begin
    ecount_next     = ecount;
    mcount_next     = mcount;
    res_popped_next = res_popped;
    res_status_next = res_status;
    elem_we         = 1'b0;
    min_we          = 1'b0;
    if (cmd.execute) begin
      res_popped_next = '0;
      res_status_next = STATUS_OK;
      if (op_mode == MODE_PUSH) begin
        if (ecount == DEPTH_CNT) begin
          res_status_next = STATUS_OVERFLOW;
        end else begin
          elem_we     = 1'b1;
          ecount_next = ecount + ONE_CNT;
          if (mcount == '0 || min_rdata >= op_value) begin
            min_we      = 1'b1;
            mcount_next = mcount + ONE_CNT;
          end
        end
      end else begin
        if (ecount == '0) begin
          res_status_next = STATUS_UNDERFLOW;
          res_popped_next = POP_EMPTY;
        end else begin
          res_popped_next = elem_rdata;
          ecount_next     = ecount_m1;
          if (mcount != '0 && min_rdata == elem_rdata) begin
            mcount_next = mcount_m1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ecount <= '0;
      mcount <= '0;
    end else begin
      ecount <= ecount_next;
      mcount <= mcount_next;
    end
  end

  always_ff @(posedge clk) begin
    res_popped <= res_popped_next;
    res_status <= res_status_next;
  end

  // Output register; the minimum comes from the re-read top of the minimum stack.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      popped_value <= res_popped;
      status       <= res_status;
      minimum      <= (mcount == '0) ? MOST_NEGATIVE : min_rdata;
      is_empty     <= (ecount == '0);
    end
  end

  `MST_ASSERT(a_min_bound, mcount <= ecount, "minimum stack deeper than element stack")
  `MST_ASSERT(a_depth_bound, ecount <= DEPTH_CNT, "element count beyond depth")
  `MST_ASSERT(a_count_step, (ecount != $past(ecount)) |-> $past(cmd.execute), "count moved outside update")

endmodule

### hdl/min_tracking_stack.sv
// Min-tracking stack: push/pop requests with the running minimum.
// Each request steps through read, update, minimum re-read and result states; the
// next is accepted once its result is loaded, as the registered read ports of the
// two stack memories set (tops read before the update, minimum re-read after it).
// Reset clears both counts, so both stacks start empty; memory contents are not
// cleared and no clearing pass runs, so requests are accepted right after reset.
module min_tracking_stack
  import mst_pkg::*;
#(
  parameter int STACK_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic signed [31:0] push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] popped_value,
  output logic [1:0]         status,
  output logic signed [31:0] minimum,
  output logic               is_empty
);

  mst_cmd_t cmd;

  mst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mst_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .mode         (mode),
    .push_value   (push_value),
    .popped_value (popped_value),
    .status       (status),
    .minimum      (minimum),
    .is_empty     (is_empty)
  );

endmodule
